// ----- design/tns_pkg.sv -----
`timescale 1ns / 1ps
// Package for the tone note sequencer: item structs, operation codes,
// state encoding and default sizes. No dependencies.
package tns_pkg;

  localparam int SONG_COUNT_DEF     = 8;
  localparam int NOTES_PER_SONG_DEF = 64;

  localparam logic [7:0] GAP_RESET = 8'd40;

  // Operation codes of an input item.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PLAY  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register index of the gap setting.
  localparam logic CFG_GAP_IDX = 1'b0;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  song;
    logic [5:0]  position;
    logic [15:0] note_freq;
    logic [15:0] note_duration;
  } in_item_t;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] tone_freq;
    logic        busy_res;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } seq_state_t;

endpackage

// ----- design/tone_note_sequencer_core.sv -----
`timescale 1ns / 1ps
// Tone note sequencer: note memory, play control and APB gap register.
// Depends on tns_pkg for item structs, operation codes and state encoding.
//
// A transfer in reads the note memory and moves the state to execute; the
// result is loaded into the output register when the item commits there, and a
// stalled result still in that register holds the commit back. A new item is
// taken only after the last commits, and the note logic runs after the read.
// Reset clears play control, tone state and the gap register (to 40 ms);
// the note memory holds no defined contents until entries are written.
module tone_note_sequencer_core #(
  parameter int SONG_COUNT     = tns_pkg::SONG_COUNT_DEF,
  parameter int NOTES_PER_SONG = tns_pkg::NOTES_PER_SONG_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tns_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tns_pkg::out_item_t   out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int SONG_W = (SONG_COUNT > 1) ? $clog2(SONG_COUNT) : 1;
  localparam int POS_AW = $clog2(NOTES_PER_SONG);
  localparam int POS_W  = $clog2(NOTES_PER_SONG + 1);
  localparam int AW     = SONG_W + POS_AW;
  localparam int DEPTH  = 2 ** AW;

  // Configuration register.
  logic [7:0] gap_ms;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ms <= tns_pkg::GAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == tns_pkg::CFG_GAP_IDX)) begin
      gap_ms <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tns_pkg::CFG_GAP_IDX) begin
      prdata = {24'd0, gap_ms};
    end
  end

  // Control and play state.
  tns_pkg::seq_state_t state;
  logic [1:0]          op_q;
  logic [SONG_W-1:0]   song_q;
  logic [SONG_W-1:0]   song_cur;
  logic [POS_W-1:0]    pos_cnt;
  logic                playing;
  logic [15:0]         wait_left;
  logic                gap_done;
  logic                tone_is_on;
  logic [15:0]         tone_hz;

  logic                in_xfer;
  logic                commit;
  logic                song_ok;
  logic [SONG_W-1:0]   song_map;
  logic                wr_ok;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [31:0]         rd_data;

  logic [31:0]         note_mem [DEPTH];

  assign in_stall = (state != tns_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign commit   = (state == tns_pkg::ST_EXEC) && (!out_valid || !out_stall);

  // Out-of-range play numbers fall back to song 0.
  assign song_ok  = ({1'b0, in_data.song} < 9'(SONG_COUNT));
  assign song_map = song_ok ? in_data.song[SONG_W-1:0] : '0;
  assign wr_ok    = song_ok && ({1'b0, in_data.position} < 7'(NOTES_PER_SONG));
  assign wr_addr  = {in_data.song[SONG_W-1:0], in_data.position[POS_AW-1:0]};
  assign rd_addr  = (in_data.op == tns_pkg::OP_PLAY) ?
                    {song_map, {POS_AW{1'b0}}} :
                    {song_cur, pos_cnt[POS_AW-1:0]};

  // Every item reads; only writes in range store. One item is in flight at a
  // time, so a read never overlaps a pending write to the same entry.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data <= note_mem[rd_addr];
      if (in_data.op == tns_pkg::OP_WRITE && wr_ok) begin
        note_mem[wr_addr] <= {in_data.note_duration, in_data.note_freq};
      end
    end
  end

  // Note logic, evaluated in the execute cycle.
  logic [POS_W-1:0]  pos_cnt_next;
  logic [SONG_W-1:0] song_cur_next;
  logic              playing_next;
  logic [15:0]       wait_left_next;
  logic              gap_done_next;
  logic              tone_is_on_next;
  logic [15:0]       tone_hz_next;
  logic [15:0]       wait_dec;
  logic [15:0]       rd_freq;
  logic [15:0]       rd_dur;

  assign rd_freq  = rd_data[15:0];
  assign rd_dur   = rd_data[31:16];
  assign wait_dec = (wait_left != 16'd0) ? (wait_left - 16'd1) : wait_left;

  always_comb begin
    pos_cnt_next    = pos_cnt;
    song_cur_next   = song_cur;
    playing_next    = playing;
    wait_left_next  = wait_left;
    gap_done_next   = gap_done;
    tone_is_on_next = tone_is_on;
    tone_hz_next    = tone_hz;
    case (op_q)
      tns_pkg::OP_PLAY: begin
        tone_hz_next    = rd_freq;
        tone_is_on_next = 1'b1;
        wait_left_next  = rd_dur;
        pos_cnt_next    = POS_W'(1);
        song_cur_next   = song_q;
        gap_done_next   = 1'b0;
        playing_next    = 1'b1;
      end
      tns_pkg::OP_TICK: begin
        if (playing) begin
          wait_left_next = wait_dec;
          if (wait_dec == 16'd0) begin
            if (pos_cnt == POS_W'(NOTES_PER_SONG)) begin
              // Past the end of the row: stop as for an end marker.
              tone_is_on_next = 1'b0;
              playing_next    = 1'b0;
            end else if (rd_freq == 16'd0) begin
              tone_is_on_next = 1'b0;
              if (rd_dur == 16'd0) begin
                playing_next = 1'b0;
              end else begin
                wait_left_next = rd_dur;
                pos_cnt_next   = pos_cnt + POS_W'(1);
              end
            end else if (!gap_done) begin
              tone_is_on_next = 1'b0;
              wait_left_next  = {8'd0, gap_ms};
              gap_done_next   = 1'b1;
            end else begin
              tone_hz_next    = rd_freq;
              tone_is_on_next = 1'b1;
              wait_left_next  = rd_dur;
              gap_done_next   = 1'b0;
              pos_cnt_next    = pos_cnt + POS_W'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tns_pkg::ST_IDLE;
      out_valid  <= 1'b0;
      song_cur   <= '0;
      pos_cnt    <= '0;
      playing    <= 1'b0;
      wait_left  <= '0;
      gap_done   <= 1'b0;
      tone_is_on <= 1'b0;
      tone_hz    <= '0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        tns_pkg::ST_IDLE: begin
          if (in_xfer) begin
            state <= tns_pkg::ST_EXEC;
          end
        end
        tns_pkg::ST_EXEC: begin
          if (commit) begin
            state      <= tns_pkg::ST_IDLE;
            song_cur   <= song_cur_next;
            pos_cnt    <= pos_cnt_next;
            playing    <= playing_next;
            wait_left  <= wait_left_next;
            gap_done   <= gap_done_next;
            tone_is_on <= tone_is_on_next;
            tone_hz    <= tone_hz_next;
          end
        end
        default: begin
          state <= tns_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q   <= in_data.op;
      song_q <= song_map;
    end
    if (commit) begin
      out_data.tone_on   <= tone_is_on_next;
      out_data.tone_freq <= tone_hz_next;
      out_data.busy_res  <= playing_next;
    end
  end

  // A stopped sequencer never keeps a pending wait.
  a_idle_no_wait: assert property (@(posedge clk) disable iff (rst)
    !playing |-> (wait_left == 16'd0))
    else $error("wait pending while not playing");

  // While playing, the note position stays within the song row.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    playing |-> (pos_cnt != '0) && (pos_cnt <= POS_W'(NOTES_PER_SONG)))
    else $error("note position out of row");

  // Only one item is in flight: a transfer in closes the input next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("second item accepted while one is in flight");

  // A committed item always shows up in the output register.
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid && (state == tns_pkg::ST_IDLE))
    else $error("committed result missing");

endmodule
